### hdl/mamn_pkg.sv
// ----------------------------------------------------------------------------
// mamn_pkg
// Constants shared by the multichannel average / min-max normalizer.
// ----------------------------------------------------------------------------
package mamn_pkg;

  // Geometry. WINDOW must be a power of two: the average is a right shift.
  localparam int CHANNELS    = 6;
  localparam int WINDOW      = 8;
  localparam int SAMPLE_BITS = 10;

  // Fixed field widths of the stream items.
  localparam int CH_BITS   = 3;
  localparam int PCT_BITS  = 7;
  localparam int LAMP_BITS = 6;

  localparam int PCT_SCALE  = 100;
  localparam int THR_RESET  = 80;

  // Derived sizes.
  localparam int CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_BITS   = $clog2(WINDOW);
  localparam int SUM_BITS   = SAMPLE_BITS + POS_BITS;
  localparam int RING_DEPTH = CHANNELS * WINDOW;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int DIVD_BITS  = SAMPLE_BITS + PCT_BITS;
  localparam int QCNT_BITS  = $clog2(PCT_BITS);

  // Stream packing.
  localparam int IN_RAW   = CH_BITS + SAMPLE_BITS;
  localparam int IN_W     = ((IN_RAW + 7) / 8) * 8;
  localparam int OUT_RAW  = CH_BITS + 3 * SAMPLE_BITS + PCT_BITS + 1 + LAMP_BITS;
  localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8;
  localparam int OUT_PAD  = OUT_W - OUT_RAW;

endpackage

### hdl/multichannel_average_minmax_normalizer_top.sv
// ----------------------------------------------------------------------------
// multichannel_average_minmax_normalizer_top
// Per-channel moving average with running min/max and percent normalization.
// ----------------------------------------------------------------------------
// Usage:
//   Samples arrive on the s_* stream (channel, sample in tdata, seed in tuser).
//   Each accepted transfer produces exactly one result transfer on m_*.
//   Per-channel state (ring position, sum, min, max) lives in a small
//   synchronous memory and the sample windows in a second one; the block
//   reads, updates and writes back one item at a time.
//   A normal update replaces the oldest window sample, writes back the
//   channel state and then forms the percent level with the seven-step
//   restoring divider; a zero min-max range skips the divider, a seed
//   writes every window entry instead, and a channel out of range goes
//   straight to the result. The user writes the threshold through
//   cfg_wr_en / cfg_wr_data only while idle; the block does not enforce this.
//   s_tready is high while the block is idle; a result waiting in the output
//   register does not block the next input transfer, but the block holds the
//   following result until the receiver takes the pending one.
//   Reset clears all windows, sums, min/max marks and lamp bits to zero (valid
//   flags make unwritten entries read as zero) and sets the threshold to 80.
// ----------------------------------------------------------------------------
module multichannel_average_minmax_normalizer_top
  import mamn_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [IN_W-1:0]     s_tdata,   // channel[2:0], sample[12:3], zero pad
  input  logic                s_tuser,   // seed
  output logic                m_tvalid,
  input  logic                m_tready,
  // channel_out[2:0], average[12:3], low_mark[22:13], high_mark[32:23],
  // level_pct[39:33], above[40], lamp_mask[46:41], zero pad
  output logic [OUT_W-1:0]    m_tdata,
  input  logic                cfg_wr_en,
  input  logic [PCT_BITS-1:0] cfg_wr_data
);

  typedef struct packed {
    logic [SUM_BITS-1:0]    sum;
    logic [POS_BITS-1:0]    pos;
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
  } chan_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CH, S_RING, S_FILL, S_MUL, S_DIV, S_FIN
  } state_t;

  state_t state;

  // Memories.
  logic [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];
  chan_t                  chan_mem [CHANNELS];
  logic [RING_DEPTH-1:0]  ring_vld;
  logic [CHANNELS-1:0]    chan_vld;
  logic [SAMPLE_BITS-1:0] ring_rd;
  logic                   ring_rd_vld;
  chan_t                  chan_rd;
  logic                   chan_rd_vld;

  // Item registers.
  logic [CH_BITS-1:0]     ch_q;
  logic [SAMPLE_BITS-1:0] smp_q;
  logic                   seed_q;
  logic                   in_range;
  logic [SUM_BITS-1:0]    c_sum;
  logic [POS_BITS-1:0]    c_pos;
  logic [SAMPLE_BITS-1:0] c_lo;
  logic [SAMPLE_BITS-1:0] c_hi;
  logic [SAMPLE_BITS-1:0] avg_q;
  logic [SAMPLE_BITS-1:0] lo_q;
  logic [SAMPLE_BITS-1:0] hi_q;
  logic [PCT_BITS-1:0]    quo;
  logic [DIVD_BITS-1:0]   rem;
  logic [SAMPLE_BITS-1:0] dvs;
  logic [QCNT_BITS-1:0]   bit_cnt;
  logic [POS_BITS-1:0]    fill_cnt;
  logic [RING_AW-1:0]     ring_base;
  logic [RING_AW-1:0]     ring_addr;
  logic [PCT_BITS-1:0]    thr;
  logic [CHANNELS-1:0]    lamp;

  // Combinational helpers.
  logic [CH_AW-1:0]       ch_idx;
  logic [CH_AW-1:0]       s_ch_idx;
  logic                   s_in_range;
  chan_t                  c_eff;
  logic [POS_BITS-1:0]    pos_eff;
  logic [POS_BITS-1:0]    pos_inc;
  logic [RING_AW-1:0]     ring_raddr;
  logic [SAMPLE_BITS-1:0] old_smp;
  logic [SUM_BITS-1:0]    sum_new;
  logic [SAMPLE_BITS-1:0] lo_new;
  logic [SAMPLE_BITS-1:0] hi_new;
  logic                   ring_we;
  logic [RING_AW-1:0]     ring_waddr;
  logic                   chan_we;
  chan_t                  chan_wdata;
  logic [SAMPLE_BITS-1:0] rng;
  logic [SAMPLE_BITS-1:0] diff;
  logic [SAMPLE_BITS-1:0] diff_clamp;
  logic [DIVD_BITS-1:0]   trial;
  logic                   above;
  logic [CHANNELS-1:0]    lamp_next;
  logic                   out_free;

  assign s_tready   = (state == S_IDLE);
  assign ch_idx     = ch_q[CH_AW-1:0];
  assign s_ch_idx   = s_tdata[CH_AW-1:0];
  assign s_in_range = {1'b0, s_tdata[CH_BITS-1:0]} < (CH_BITS + 1)'(CHANNELS);
  assign out_free   = !m_tvalid || m_tready;

  always_comb begin
    c_eff = chan_rd_vld ? chan_rd : '0;
    if ({1'b0, c_eff.pos} >= (POS_BITS + 1)'(WINDOW)) begin
      pos_eff = '0;
    end else begin
      pos_eff = c_eff.pos;
    end
    if ({1'b0, c_pos} + (POS_BITS + 1)'(1) == (POS_BITS + 1)'(WINDOW)) begin
      pos_inc = '0;
    end else begin
      pos_inc = c_pos + POS_BITS'(1);
    end
    ring_raddr = ring_base + RING_AW'(pos_eff);

    old_smp = ring_rd_vld ? ring_rd : '0;
    sum_new = c_sum - SUM_BITS'(old_smp) + SUM_BITS'(smp_q);
    lo_new  = (smp_q < c_lo) ? smp_q : c_lo;
    hi_new  = (smp_q > c_hi) ? smp_q : c_hi;

    ring_we    = (state == S_RING) || (state == S_FILL);
    ring_waddr = (state == S_FILL) ? ring_base + RING_AW'(fill_cnt) : ring_addr;

    chan_we    = (state == S_RING) || ((state == S_FILL) && (fill_cnt == '0));
    if (state == S_FILL) begin
      chan_wdata.sum = SUM_BITS'(smp_q) << POS_BITS;
      chan_wdata.pos = '0;
      chan_wdata.lo  = smp_q;
      chan_wdata.hi  = smp_q;
    end else begin
      chan_wdata.sum = sum_new;
      chan_wdata.pos = pos_inc;
      chan_wdata.lo  = lo_new;
      chan_wdata.hi  = hi_new;
    end

    // Clamping the difference to the range gives the same result as
    // saturating the quotient at the full scale.
    rng        = hi_q - lo_q;
    diff       = (avg_q > lo_q) ? avg_q - lo_q : '0;
    diff_clamp = (diff > rng) ? rng : diff;
    trial      = DIVD_BITS'(dvs) << bit_cnt;

    above     = in_range && (quo >= thr);
    lamp_next = lamp;
    if (in_range) begin
      lamp_next[ch_idx] = above;
    end
  end

  // Sample windows and channel state, with registered reads.
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= smp_q;
    end
    ring_rd <= ring_mem[ring_raddr];
    if (chan_we) begin
      chan_mem[ch_idx] <= chan_wdata;
    end
    chan_rd <= chan_mem[s_ch_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      m_tvalid    <= 1'b0;
      ring_vld    <= '0;
      chan_vld    <= '0;
      lamp        <= '0;
      thr         <= PCT_BITS'(THR_RESET);
    end else begin
      if (cfg_wr_en) begin
        thr <= cfg_wr_data;
      end
      // In S_FIN the output register is reloaded instead when it is free.
      if (m_tvalid && m_tready && (state != S_FIN)) begin
        m_tvalid <= 1'b0;
      end
      ring_rd_vld <= ring_vld[ring_raddr];
      if (ring_we) begin
        ring_vld[ring_waddr] <= 1'b1;
      end
      if (chan_we) begin
        chan_vld[ch_idx] <= 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            ch_q        <= s_tdata[CH_BITS-1:0];
            smp_q       <= s_tdata[CH_BITS +: SAMPLE_BITS];
            seed_q      <= s_tuser;
            in_range    <= s_in_range;
            ring_base   <= RING_AW'(s_ch_idx) * RING_AW'(WINDOW);
            chan_rd_vld <= chan_vld[s_ch_idx];
            avg_q       <= '0;
            lo_q        <= '0;
            hi_q        <= '0;
            quo         <= '0;
            state       <= s_in_range ? S_CH : S_FIN;
          end
        end
        S_CH: begin
          c_sum     <= c_eff.sum;
          c_pos     <= pos_eff;
          c_lo      <= c_eff.lo;
          c_hi      <= c_eff.hi;
          ring_addr <= ring_raddr;
          fill_cnt  <= '0;
          state     <= seed_q ? S_FILL : S_RING;
        end
        S_RING: begin
          avg_q <= sum_new[POS_BITS +: SAMPLE_BITS];
          lo_q  <= lo_new;
          hi_q  <= hi_new;
          state <= S_MUL;
        end
        S_FILL: begin
          fill_cnt <= fill_cnt + POS_BITS'(1);
          if ({1'b0, fill_cnt} == (POS_BITS + 1)'(WINDOW - 1)) begin
            avg_q <= smp_q;
            lo_q  <= smp_q;
            hi_q  <= smp_q;
            state <= S_FIN;
          end
        end
        S_MUL: begin
          rem     <= DIVD_BITS'(diff_clamp) * DIVD_BITS'(PCT_SCALE);
          dvs     <= rng;
          bit_cnt <= QCNT_BITS'(PCT_BITS - 1);
          state   <= (hi_q > lo_q) ? S_DIV : S_FIN;
        end
        S_DIV: begin
          if (rem >= trial) begin
            rem          <= rem - trial;
            quo[bit_cnt] <= 1'b1;
          end
          bit_cnt <= bit_cnt - QCNT_BITS'(1);
          if (bit_cnt == '0) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            lamp     <= lamp_next;
            m_tvalid <= 1'b1;
            m_tdata  <= {{OUT_PAD{1'b0}}, LAMP_BITS'(lamp_next), above, quo,
                         hi_q, lo_q, avg_q, ch_q};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multichannel average / min-max normalizer. A
// scoreboard class keeps its own copy of the per-channel windows, sums,
// min/max marks and lamp bits and predicts every result from the accepted
// input stream. Directed samples cover the seed and out-of-range cases and the
// sample extremes. Random phases under several thresholds follow, with random
// gaps on both streams and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  import mamn_pkg::*;

  typedef struct packed {
    logic [OUT_PAD-1:0]     pad;
    logic [LAMP_BITS-1:0]   lamp_mask;
    logic                   above;
    logic [PCT_BITS-1:0]    level_pct;
    logic [SAMPLE_BITS-1:0] high_mark, low_mark, average;
    logic [CH_BITS-1:0]     channel;
  } level_result_t;

  class normalizer_scoreboard;
    logic [SAMPLE_BITS-1:0] ring [CHANNELS][WINDOW];
    logic [SUM_BITS-1:0]    sum [CHANNELS];
    logic [POS_BITS-1:0]    pos [CHANNELS];
    logic [SAMPLE_BITS-1:0] lo_mark [CHANNELS];
    logic [SAMPLE_BITS-1:0] hi_mark [CHANNELS];
    logic [LAMP_BITS-1:0]   lamps;
    logic [PCT_BITS-1:0]    threshold;
    level_result_t          expected_q[$];
    int                     errors;
    int                     results_seen;

    function new();
      for (int c = 0; c < CHANNELS; c++) begin
        for (int j = 0; j < WINDOW; j++) ring[c][j] = '0;
        sum[c] = '0;
        pos[c] = '0;
        lo_mark[c] = '0;
        hi_mark[c] = '0;
      end
      lamps = '0;
      threshold = PCT_BITS'(THR_RESET);
      errors = 0;
      results_seen = 0;
    endfunction

    // Updates the channel state for one accepted sample and queues its result.
    function void note_sample(logic [CH_BITS-1:0] ch, logic [SAMPLE_BITS-1:0] smp,
                              logic seed);
      level_result_t r;
      int p, avg, lvl, span, diff;
      r = '0;
      r.channel = ch;
      if (ch < CHANNELS) begin
        if (seed) begin
          for (int j = 0; j < WINDOW; j++) ring[ch][j] = smp;
          sum[ch] = SUM_BITS'(smp * WINDOW);
          pos[ch] = '0;
          lo_mark[ch] = smp;
          hi_mark[ch] = smp;
          avg = smp;
          lvl = 0;
        end else begin
          p = pos[ch];
          sum[ch] = sum[ch] - ring[ch][p] + smp;
          ring[ch][p] = smp;
          pos[ch] = POS_BITS'((p + 1) % WINDOW);
          avg = sum[ch] / WINDOW;
          if (smp < lo_mark[ch]) lo_mark[ch] = smp;
          if (smp > hi_mark[ch]) hi_mark[ch] = smp;
          span = int'(hi_mark[ch]) - int'(lo_mark[ch]);
          if (span <= 0) begin
            lvl = 0;
          end else begin
            diff = (avg > lo_mark[ch]) ? avg - int'(lo_mark[ch]) : 0;
            lvl = (diff * PCT_SCALE) / span;
            if (lvl > PCT_SCALE) lvl = PCT_SCALE;
          end
        end
        r.above = (lvl >= threshold);
        lamps[ch] = r.above;
        r.average = SAMPLE_BITS'(avg);
        r.low_mark = lo_mark[ch];
        r.high_mark = hi_mark[ch];
        r.level_pct = PCT_BITS'(lvl);
      end
      r.lamp_mask = lamps;
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %0h, expected %0h", results_seen, name,
                         got, want));
    endtask

    task check_result(logic [OUT_W-1:0] data);
      level_result_t got, want;
      got = level_result_t'(data);
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing pending: %h", results_seen,
                         data));
      end else begin
        want = expected_q.pop_front();
        compare_field("channel_out", got.channel, want.channel);
        compare_field("average", got.average, want.average);
        compare_field("low_mark", got.low_mark, want.low_mark);
        compare_field("high_mark", got.high_mark, want.high_mark);
        compare_field("level_pct", got.level_pct, want.level_pct);
        compare_field("above", got.above, want.above);
        compare_field("lamp_mask", got.lamp_mask, want.lamp_mask);
        compare_field("pad", got.pad, want.pad);
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata;   // channel[2:0], sample[12:3], zero pad
  logic                s_tuser;   // seed
  logic                m_tvalid;
  logic                m_tready;
  // channel_out[2:0], average[12:3], low_mark[22:13], high_mark[32:23],
  // level_pct[39:33], above[40], lamp_mask[46:41], zero pad
  logic [OUT_W-1:0]    m_tdata;
  logic                cfg_wr_en;
  logic [PCT_BITS-1:0] cfg_wr_data;

  normalizer_scoreboard sb = new();

  multichannel_average_minmax_normalizer_top uut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 11);
  endfunction

  // Offers one sample and waits for its transfer. Valid stays high when no gap
  // follows, so back-to-back samples never toggle it within one step.
  task automatic push_sample(logic [CH_BITS-1:0] ch, logic [SAMPLE_BITS-1:0] smp,
                             logic seed, int gap);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_W - IN_RAW){1'b0}}, smp, ch};
    s_tuser  <= seed;
    do @(posedge clk); while (!s_tready);
    sb.note_sample(ch, smp, seed);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops the sender, lets every pending result drain, then writes the threshold.
  task automatic set_threshold(logic [PCT_BITS-1:0] value);
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    sb.threshold = value;
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random stalls, quiet stretches without stalls, and one long
  // hold-off so that the block backs up into its input.
  initial begin
    int stall_left, cycle_cnt;
    bit steady, long_hold_done;
    stall_left = 0;
    cycle_cnt = 0;
    steady = 1'b0;
    long_hold_done = 1'b0;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (!long_hold_done && sb.results_seen >= 120) begin
        stall_left = 600;
        long_hold_done = 1'b1;
      end
      cycle_cnt++;
      if (cycle_cnt % 256 == 0) steady = ($urandom_range(3) == 0);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!steady && $urandom_range(99) < 25) begin
        stall_left = gap_len();
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [PCT_BITS-1:0] phase_thr [6];
    logic [CH_BITS-1:0] ch;
    logic [SAMPLE_BITS-1:0] smp;
    logic seed;
    int drift [CHANNELS];
    int r, v, w;

    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tuser     <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    rst         <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset threshold.
    push_sample(0, 0, 0, 0);           // all-zero state, zero range
    push_sample(0, 1023, 0, 1);        // full-scale jump from zero
    push_sample(1, 1023, 1, 0);        // seed at full scale
    push_sample(1, 0, 0, 0);           // average near the top of the range
    push_sample(5, 0, 1, 2);
    for (int i = 0; i < 8; i++) push_sample(5, 1023, 0, i % 2);  // window wraps
    push_sample(6, 1023, 0, 0);        // channels past the last one
    push_sample(7, 1023, 1, 0);
    push_sample(7, 0, 0, 3);
    push_sample(2, 512, 1, 0);
    push_sample(2, 512, 0, 0);         // seeded channel, still zero range
    push_sample(4, 5, 1, 0);
    push_sample(4, 1023, 0, 0);

    for (int c = 0; c < CHANNELS; c++) drift[c] = $urandom_range(1023);
    phase_thr[0] = 0;
    phase_thr[1] = 127;
    phase_thr[2] = 100;
    phase_thr[3] = 101;
    phase_thr[4] = 50;
    phase_thr[5] = PCT_BITS'($urandom_range(99, 1));

    for (int ph = 0; ph < 6; ph++) begin
      set_threshold(phase_thr[ph]);
      for (int i = 0; i < 150; i++) begin
        r = $urandom_range(99);
        ch = CH_BITS'($urandom_range(CHANNELS - 1));
        seed = 1'b0;
        smp = SAMPLE_BITS'($urandom);
        if (r < 8) begin
          ch = CH_BITS'($urandom_range(7, CHANNELS));
          seed = 1'($urandom_range(1));
        end else if (r < 13) begin
          seed = 1'b1;
        end else if (r < 23) begin
          smp = SAMPLE_BITS'($urandom_range(1) ? 1023 : 0);
        end else if (r >= 50) begin
          // Slowly wandering signal with some noise keeps levels spread out.
          drift[ch] += int'($urandom_range(80)) - 40;
          if (drift[ch] < 0) drift[ch] = 0;
          if (drift[ch] > 1023) drift[ch] = 1023;
          v = drift[ch] + int'($urandom_range(30)) - 15;
          if (v < 0) v = 0;
          if (v > 1023) v = 1023;
          smp = SAMPLE_BITS'(v);
        end
        push_sample(ch, smp, seed, (ph % 2 == 1) ? 0 : gap_len());
      end
    end

    s_tvalid <= 1'b0;
    for (w = 0; w < 20000 && sb.expected_q.size() != 0; w++) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
